// ===== rtl/balance_cascade_pid_core_assert.svh =====
// Assertion macros for the balance controller checker.
// Both forms sample on the rising edge of clock and are off while reset is high.
`ifndef BALANCE_CASCADE_PID_CORE_ASSERT_SVH
`define BALANCE_CASCADE_PID_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BCP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BCP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bcp_pkg.sv =====
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared widths, register codes, reset values and types of the balance core.
// ----------------------------------------------------------------------------
`default_nettype none

package bcp_pkg;

   localparam int SENS_W     = 16;  // speeds, counts, gyro rates
   localparam int ANGLE_W    = 25;  // Q8.16 angles
   localparam int GAIN_W     = 32;  // Q16.16 gains
   localparam int DRIVE_W    = 16;
   localparam int E_W        = 18;  // speed error and filter state
   localparam int INTEG_W    = 15;  // integral state
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = 2 * GAIN_W;
   localparam int ACC_W      = 35;  // first filter product
   localparam int VEL_W      = 35;  // velocity term, whole degrees
   localparam int TERM_W     = 32;  // upright and turn partial terms
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int INTEGRAL_LIMIT_DEF = 10000;
   localparam int QUEUE_DEPTH_DEF    = 2;

   localparam logic signed [GAIN_W-1:0] FILT_OLD = 32'sd45875;
   localparam logic signed [GAIN_W-1:0] FILT_NEW = 32'sd19661;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TRIM_ANGLE = 3'd0,
      REG_UPRIGHT_KP = 3'd1,
      REG_UPRIGHT_KD = 3'd2,
      REG_SPEED_KP   = 3'd3,
      REG_SPEED_KI   = 3'd4,
      REG_TURN_GAIN  = 3'd5
   } csr_idx_type;

   localparam logic signed [ANGLE_W-1:0] TRIM_ANGLE_RST = 25'sd257743;
   localparam logic signed [GAIN_W-1:0]  UPRIGHT_KP_RST = 32'sd13107200;
   localparam logic signed [GAIN_W-1:0]  UPRIGHT_KD_RST = 32'sd32768;
   localparam logic signed [GAIN_W-1:0]  SPEED_KP_RST   = 32'sd19661;
   localparam logic signed [GAIN_W-1:0]  SPEED_KI_RST   = 32'sd98;
   localparam logic signed [GAIN_W-1:0]  TURN_GAIN_RST  = -32'sd39322;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] trim_angle;
      logic signed [GAIN_W-1:0]  upright_kp;
      logic signed [GAIN_W-1:0]  upright_kd;
      logic signed [GAIN_W-1:0]  speed_kp;
      logic signed [GAIN_W-1:0]  speed_ki;
      logic signed [GAIN_W-1:0]  turn_gain;
   } cfg_type;

   // one queued control tick, speed error already formed
   typedef struct packed {
      logic signed [E_W-1:0]     speed_err;
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [SENS_W-1:0]  gyro_y;
      logic signed [SENS_W-1:0]  gyro_z;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

`default_nettype wire

// ===== rtl/bcp_if.sv =====
// ----------------------------------------------------------------------------
// bcp_if
// Valid/ready channel interfaces: tick request, drive response, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcp_req_if import bcp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SENS_W-1:0]  speed_goal;
   logic signed [SENS_W-1:0]  left_count;
   logic signed [SENS_W-1:0]  right_count;
   logic signed [ANGLE_W-1:0] roll_angle;
   logic signed [SENS_W-1:0]  gyro_y;
   logic signed [SENS_W-1:0]  gyro_z;

   modport source (output valid, speed_goal, left_count, right_count, roll_angle,
                   gyro_y, gyro_z, input ready);
   modport sink (input valid, speed_goal, left_count, right_count, roll_angle,
                 gyro_y, gyro_z, output ready);
endinterface

interface bcp_rsp_if import bcp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] left_drive;
   logic signed [DRIVE_W-1:0] right_drive;

   modport source (output valid, left_drive, right_drive, input ready);
   modport sink (input valid, left_drive, right_drive, output ready);
endinterface

interface bcp_csr_if import bcp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcp_front.sv =====
// ----------------------------------------------------------------------------
// bcp_front
// Request intake: forms the speed error and pushes the tick into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_front import bcp_pkg::*; (
   bcp_req_if.sink        req,
   input  q_stat_type     q_stat,
   output logic           push,
   output item_type       push_item
);

   logic signed [E_W-1:0] left_x;
   logic signed [E_W-1:0] right_x;
   logic signed [E_W-1:0] goal_x;

   assign req.ready = !q_stat.full;
   assign push      = req.valid && !q_stat.full;

   assign left_x  = {{(E_W-SENS_W){req.left_count[SENS_W-1]}}, req.left_count};
   assign right_x = {{(E_W-SENS_W){req.right_count[SENS_W-1]}}, req.right_count};
   assign goal_x  = {{(E_W-SENS_W){req.speed_goal[SENS_W-1]}}, req.speed_goal};

   always_comb begin
      push_item.speed_err  = left_x + right_x - goal_x;
      push_item.roll_angle = req.roll_angle;
      push_item.gyro_y     = req.gyro_y;
      push_item.gyro_z     = req.gyro_z;
   end

endmodule

`default_nettype wire

// ===== rtl/bcp_queue.sv =====
// ----------------------------------------------------------------------------
// bcp_queue
// Short FIFO between intake and the arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_queue import bcp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  item_type   push_item,
   input  logic       pop,
   output item_type   head_item,
   output q_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head_item    = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bcp_back.sv =====
// ----------------------------------------------------------------------------
// bcp_back
// Control-law sequencer: one shared 32x32 multiplier, loop state, drive output.
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_back import bcp_pkg::*; #(
   parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  q_stat_type  q_stat,
   input  item_type    head_item,
   output logic        pop,
   bcp_rsp_if.source   rsp
);

   localparam int ISUM_W = E_W + 1;
   localparam int ANGW   = VEL_W + FRAC_W + 2;
   localparam int DSUM_W = TERM_W + 3;

   localparam logic signed [ISUM_W-1:0] LIM_HI  = ISUM_W'(INTEGRAL_LIMIT);
   localparam logic signed [ISUM_W-1:0] LIM_LO  = -LIM_HI;
   localparam logic signed [DSUM_W-1:0] DRV_MAX = DSUM_W'(2 ** (DRIVE_W - 1) - 1);
   localparam logic signed [DSUM_W-1:0] DRV_MIN = -DRV_MAX - DSUM_W'(1);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_FILT_OLD = 10'b0000000010,
      ST_FILT_NEW = 10'b0000000100,
      ST_FILT_SUM = 10'b0000001000,
      ST_SPEED_P  = 10'b0000010000,
      ST_SPEED_I  = 10'b0000100000,
      ST_TURN     = 10'b0001000000,
      ST_ANGLE    = 10'b0010000000,
      ST_UPRIGHT  = 10'b0100000000,
      ST_DRIVE    = 10'b1000000000
   } state_type;

   // x / 2^s rounded toward zero
   function automatic logic signed [PROD_W-1:0] trunc_shift(
      input logic signed [PROD_W-1:0] x,
      input logic [5:0]               s
   );
      logic signed [PROD_W-1:0] bias;
      bias = x[PROD_W-1] ? ((PROD_W'(1) << s) - PROD_W'(1)) : '0;
      return (x + bias) >>> s;
   endfunction

   function automatic logic signed [DRIVE_W-1:0] sat_drive(
      input logic signed [DSUM_W-1:0] x
   );
      logic signed [DRIVE_W-1:0] r;
      if (x > DRV_MAX) begin
         r = DRV_MAX[DRIVE_W-1:0];
      end else if (x < DRV_MIN) begin
         r = DRV_MIN[DRIVE_W-1:0];
      end else begin
         r = x[DRIVE_W-1:0];
      end
      return r;
   endfunction

   state_type                  state_ff, state_in;
   item_type                   item_ff, item_in;
   logic signed [E_W-1:0]      fe_ff, fe_in;
   logic signed [INTEG_W-1:0]  ie_ff, ie_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [VEL_W-1:0]    vel_ff, vel_in;
   logic signed [TERM_W-1:0]   u2_ff, u2_in;
   logic signed [TERM_W-1:0]   t_ff, t_in;
   logic signed [GAIN_W-1:0]   ang_ff, ang_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0]  ld_ff, ld_in;
   logic signed [DRIVE_W-1:0]  rd_ff, rd_in;

   logic signed [GAIN_W-1:0]   mul_a;
   logic signed [GAIN_W-1:0]   mul_b;
   logic                       mul_en;
   logic                       out_free;
   logic                       load_out;
   logic signed [PROD_W-1:0]   filt_sum;
   logic signed [PROD_W-1:0]   filt_q16;
   logic signed [PROD_W-1:0]   prod_q16;
   logic signed [PROD_W-1:0]   prod_q32;
   logic signed [ISUM_W-1:0]   isum;
   logic signed [ANGW-1:0]     ang_wide;
   logic [ANGW-GAIN_W:0]       ang_upper;
   logic signed [TERM_W-1:0]   u1;
   logic signed [DSUM_W-1:0]   up_sum;
   logic signed [DSUM_W-1:0]   turn_x;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign mul_en   = state_ff inside {ST_FILT_OLD, ST_FILT_NEW, ST_FILT_SUM, ST_SPEED_P,
                                      ST_SPEED_I, ST_TURN, ST_UPRIGHT};

   // multiplier operand select; the product is registered in prod_ff
   always_comb begin
      case (state_ff)
         ST_FILT_OLD: begin
            mul_a = FILT_OLD;
            mul_b = {{(GAIN_W-E_W){fe_ff[E_W-1]}}, fe_ff};
         end
         ST_FILT_NEW: begin
            mul_a = FILT_NEW;
            mul_b = {{(GAIN_W-E_W){item_ff.speed_err[E_W-1]}}, item_ff.speed_err};
         end
         ST_FILT_SUM: begin
            mul_a = cfg.upright_kd;
            mul_b = {{(GAIN_W-SENS_W){item_ff.gyro_y[SENS_W-1]}}, item_ff.gyro_y};
         end
         ST_SPEED_P: begin
            mul_a = cfg.speed_kp;
            mul_b = {{(GAIN_W-E_W){fe_ff[E_W-1]}}, fe_ff};
         end
         ST_SPEED_I: begin
            mul_a = cfg.speed_ki;
            mul_b = {{(GAIN_W-INTEG_W){ie_ff[INTEG_W-1]}}, ie_ff};
         end
         ST_TURN: begin
            mul_a = cfg.turn_gain;
            mul_b = {{(GAIN_W-SENS_W){item_ff.gyro_z[SENS_W-1]}}, item_ff.gyro_z};
         end
         ST_UPRIGHT: begin
            mul_a = cfg.upright_kp;
            mul_b = ang_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // datapath on the registered product
   always_comb begin
      prod_q16  = trunc_shift(prod_ff, 6'(FRAC_W));
      prod_q32  = trunc_shift(prod_ff, 6'(2 * FRAC_W));
      filt_sum  = {{(PROD_W-ACC_W){acc_ff[ACC_W-1]}}, acc_ff} + prod_ff;
      filt_q16  = trunc_shift(filt_sum, 6'(FRAC_W));
      isum      = {{(ISUM_W-INTEG_W){ie_ff[INTEG_W-1]}}, ie_ff}
                + {{(ISUM_W-E_W){fe_ff[E_W-1]}}, fe_ff};
      ang_wide  = {{(ANGW-ANGLE_W){item_ff.roll_angle[ANGLE_W-1]}}, item_ff.roll_angle}
                - {{(ANGW-VEL_W-FRAC_W){vel_ff[VEL_W-1]}}, vel_ff, {FRAC_W{1'b0}}}
                - {{(ANGW-ANGLE_W){cfg.trim_angle[ANGLE_W-1]}}, cfg.trim_angle};
      // sign bit of the 32-bit result and everything above it
      ang_upper = ang_wide[ANGW-1:GAIN_W-1];
      u1        = prod_q32[TERM_W-1:0];
      up_sum    = {{(DSUM_W-TERM_W){u1[TERM_W-1]}}, u1}
                + {{(DSUM_W-TERM_W){u2_ff[TERM_W-1]}}, u2_ff};
      turn_x    = {{(DSUM_W-TERM_W){t_ff[TERM_W-1]}}, t_ff};
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      fe_in    = fe_ff;
      ie_in    = ie_ff;
      acc_in   = acc_ff;
      vel_in   = vel_ff;
      u2_in    = u2_ff;
      t_in     = t_ff;
      ang_in   = ang_ff;
      ld_in    = ld_ff;
      rd_in    = rd_ff;
      pop      = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               item_in  = head_item;
               state_in = ST_FILT_OLD;
            end
         end
         ST_FILT_OLD: state_in = ST_FILT_NEW;
         ST_FILT_NEW: begin
            acc_in   = prod_ff[ACC_W-1:0];
            state_in = ST_FILT_SUM;
         end
         ST_FILT_SUM: begin
            fe_in    = filt_q16[E_W-1:0];
            state_in = ST_SPEED_P;
         end
         ST_SPEED_P: begin
            u2_in = prod_q16[TERM_W-1:0];
            if (isum > LIM_HI) begin
               ie_in = LIM_HI[INTEG_W-1:0];
            end else if (isum < LIM_LO) begin
               ie_in = LIM_LO[INTEG_W-1:0];
            end else begin
               ie_in = isum[INTEG_W-1:0];
            end
            state_in = ST_SPEED_I;
         end
         ST_SPEED_I: begin
            vel_in   = prod_q16[VEL_W-1:0];
            state_in = ST_TURN;
         end
         ST_TURN: begin
            vel_in   = vel_ff + prod_q16[VEL_W-1:0];
            state_in = ST_ANGLE;
         end
         ST_ANGLE: begin
            t_in = prod_q16[TERM_W-1:0];
            // saturate tilt error to 32 bits
            if (!ang_wide[ANGW-1] && (|ang_upper)) begin
               ang_in = {1'b0, {(GAIN_W-1){1'b1}}};
            end else if (ang_wide[ANGW-1] && !(&ang_upper)) begin
               ang_in = {1'b1, {(GAIN_W-1){1'b0}}};
            end else begin
               ang_in = ang_wide[GAIN_W-1:0];
            end
            state_in = ST_UPRIGHT;
         end
         ST_UPRIGHT: state_in = ST_DRIVE;
         ST_DRIVE: begin
            if (out_free) begin
               load_out = 1'b1;
               ld_in    = sat_drive(up_sum + turn_x);
               rd_in    = sat_drive(up_sum - turn_x);
               if (!q_stat.empty) begin
                  pop      = 1'b1;
                  item_in  = head_item;
                  state_in = ST_FILT_OLD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fe_ff        <= '0;
         ie_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fe_ff        <= fe_in;
         ie_ff        <= ie_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      acc_ff  <= acc_in;
      vel_ff  <= vel_in;
      u2_ff   <= u2_in;
      t_ff    <= t_in;
      ang_ff  <= ang_in;
      ld_ff   <= ld_in;
      rd_ff   <= rd_in;
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.left_drive  = ld_ff;
   assign rsp.right_drive = rd_ff;

endmodule

`default_nettype wire

// ===== rtl/balance_cascade_pid_core.sv =====
// ----------------------------------------------------------------------------
// balance_cascade_pid_core
// Cascaded velocity / upright / turn controller for a two-wheeled balancer.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  - one control tick per transaction: target speed, encoder counts,
//              roll angle, gyro y and z rates.
//   rsp_bus  - one transaction per tick: left and right drive, saturated s16.
//   csr_bus  - register writes (index, data), always ready; write only while
//              no tick is in flight. Unknown indexes are dropped.
// Timing:
//   A tick runs through the sequencer states FILT_OLD, FILT_NEW, FILT_SUM,
//   SPEED_P, SPEED_I, TURN, ANGLE, UPRIGHT and DRIVE; the next tick starts
//   after DRIVE, as the seven products share the single 32x32 multiplier.
//   A small queue (QUEUE_DEPTH ticks) keeps accepting while the sequencer
//   works or while a finished response waits.
// Reset:
//   Synchronous, active high. Gains return to their defaults, filter and
//   integral state clear, queue empties, no response is valid.
// Stall:
//   A held response keeps its drives stable; the sequencer then waits with
//   the next result and the queue fills until req ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module balance_cascade_pid_core import bcp_pkg::*; #(
   parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bcp_req_if.sink     req_bus,
   bcp_rsp_if.source   rsp_bus,
   bcp_csr_if.sink     csr_bus
);

   cfg_type     cfg_ff, cfg_in;
   q_stat_type  q_stat;
   logic        push;
   logic        pop;
   item_type    push_item;
   item_type    head_item;

   // register file: always ready; the user must see that config is only written while idle, the block has no check
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_idx_type'(csr_bus.index))
            REG_TRIM_ANGLE: cfg_in.trim_angle = csr_bus.data[ANGLE_W-1:0];
            REG_UPRIGHT_KP: cfg_in.upright_kp = csr_bus.data[GAIN_W-1:0];
            REG_UPRIGHT_KD: cfg_in.upright_kd = csr_bus.data[GAIN_W-1:0];
            REG_SPEED_KP:   cfg_in.speed_kp   = csr_bus.data[GAIN_W-1:0];
            REG_SPEED_KI:   cfg_in.speed_ki   = csr_bus.data[GAIN_W-1:0];
            REG_TURN_GAIN:  cfg_in.turn_gain  = csr_bus.data[GAIN_W-1:0];
            default:        cfg_in = cfg_ff;  // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trim_angle <= TRIM_ANGLE_RST;
         cfg_ff.upright_kp <= UPRIGHT_KP_RST;
         cfg_ff.upright_kd <= UPRIGHT_KD_RST;
         cfg_ff.speed_kp   <= SPEED_KP_RST;
         cfg_ff.speed_ki   <= SPEED_KI_RST;
         cfg_ff.turn_gain  <= TURN_GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: take the tick, form speed error
   bcp_front u_front (
      .req       (req_bus),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   // decoupling queue
   bcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   // back: multiply sequence, loop state, output register
   bcp_back #(
      .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .head_item (head_item),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== rtl/bcp_checker.sv =====
// ----------------------------------------------------------------------------
// bcp_checker
// Port-level checks on the balance core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "balance_cascade_pid_core_assert.svh"

module bcp_checker import bcp_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [DRIVE_W-1:0] rsp_left,
   input logic signed [DRIVE_W-1:0] rsp_right,
   input logic                      csr_ready
);

   // stalled response holds its drives
   `BCP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_left) && $stable(rsp_right), "response changed while stalled")

   // nothing is presented right after reset
   `BCP_ASSERT_NOW(a_rsp_after_reset, $past(reset), !rsp_valid, "response valid after reset")

   // register writes never back-pressure
   `BCP_ASSERT_NOW(a_csr_ready, 1'b1, csr_ready, "register port not ready")

endmodule

bind balance_cascade_pid_core bcp_checker u_bcp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_left  (rsp_bus.left_drive),
   .rsp_right (rsp_bus.right_drive),
   .csr_ready (csr_bus.ready)
);

`default_nettype wire

// ===== bench/tb_balance_cascade_pid_core.sv =====
// ----------------------------------------------------------------------------
// tb_balance_cascade_pid_core
// Self-checking bench for the cascaded velocity / upright / turn controller:
// ticks go through a randomly idling driver, every drive pair is checked
// against a bit-true fixed-point model of the three loops, across several gain
// settings including the extremes.
// ----------------------------------------------------------------------------

module tb_balance_cascade_pid_core;
   import bcp_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 8;
   // No-transaction cycles before we give up. Worst legal quiet stretch is the
   // forced HOLD_CYCLES hold plus a long stall, a long gap and the pipe.
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 16;

   // spare register slots, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   // controller constants, kept independent of the design's package
   localparam longint FILTER_KEEP  = 45875;   // 0.7 in Q16
   localparam longint FILTER_GAIN  = 19661;   // 0.3 in Q16
   localparam longint INTEG_LIMIT  = 10000;
   localparam longint ANGLE_MAX    = 64'sd2147483647;
   localparam longint ANGLE_MIN    = -64'sd2147483648;
   localparam longint DRIVE_MAX    = 32767;
   localparam longint DRIVE_MIN    = -32768;
   localparam longint TRIM_ANGLE_DEF = 257743;
   localparam longint UPRIGHT_KP_DEF = 13107200;
   localparam longint UPRIGHT_KD_DEF = 32768;
   localparam longint SPEED_KP_DEF   = 19661;
   localparam longint SPEED_KI_DEF   = 98;
   localparam longint TURN_GAIN_DEF  = -39322;
   localparam int     ANGLE_SPAN     = 11796480;  // +-180 degrees in Q8.16

   typedef struct {
      logic signed [SENS_W-1:0]  speed_goal;
      logic signed [SENS_W-1:0]  left_count;
      logic signed [SENS_W-1:0]  right_count;
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [SENS_W-1:0]  gyro_y;
      logic signed [SENS_W-1:0]  gyro_z;
   } tick_type;

   typedef struct {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
   } drive_pair_type;

   logic clock;
   logic reset;

   bcp_req_if req_bus ();
   bcp_rsp_if rsp_bus ();
   bcp_csr_if csr_bus ();

   balance_cascade_pid_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // ticks waiting for the driver, drive pairs waiting for the DUT
   tick_type       tick_backlog[$];
   drive_pair_type expected_drives[$];

   // model copy of registers and loop state
   longint trim_angle_q, upright_kp_q, upright_kd_q, speed_kp_q, speed_ki_q, turn_gain_q;
   longint filt_err, err_integ;

   // handshake observations, updated at the rising edge
   logic req_took;
   logic csr_took;
   int   ticks_taken;
   int   drives_checked;
   int   reg_writes;
   int   input_stall_cycles;
   int   idle_cycles;
   int   mismatches;

   // stimulus bookkeeping
   int   ticks_queued;
   int   settings_run;
   logic req_eager;       // sender ignores its gaps (used while the sink is held off)
   int   hold_asked;
   int   hold_served;

   // driver pacing
   int req_gap, req_calm;
   int rsp_stall, rsp_calm, hold_left;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model of the three loops
   // ------------------------------------------------------------------------

   // divide by 2^sh, rounding toward zero
   function automatic longint trunc_div(longint x, int sh);
      if (x < 0)
         return -((-x) >>> sh);
      return x >>> sh;
   endfunction

   function automatic longint clip(longint x, longint lo, longint hi);
      if (x < lo)
         return lo;
      if (x > hi)
         return hi;
      return x;
   endfunction

   // Advances filter and integral by one tick and returns the drive pair.
   function automatic drive_pair_type predict_drives(tick_type t);
      longint speed_err, vel, tilt_err, upright, turn;
      drive_pair_type d;
      speed_err = longint'(t.left_count) + longint'(t.right_count)
                  - longint'(t.speed_goal);
      filt_err  = trunc_div(FILTER_KEEP * filt_err + FILTER_GAIN * speed_err, 16);
      err_integ = clip(err_integ + filt_err, -INTEG_LIMIT, INTEG_LIMIT);
      // velocity term comes out in whole degrees, moved to Q8.16 below
      vel = trunc_div(speed_kp_q * filt_err, 16) + trunc_div(speed_ki_q * err_integ, 16);
      tilt_err = clip(longint'(t.roll_angle) - vel * 65536 - trim_angle_q,
                      ANGLE_MIN, ANGLE_MAX);
      upright = trunc_div(upright_kp_q * tilt_err, 32)
                + trunc_div(upright_kd_q * longint'(t.gyro_y), 16);
      turn    = trunc_div(turn_gain_q * longint'(t.gyro_z), 16);
      d.left_drive  = DRIVE_W'(clip(upright + turn, DRIVE_MIN, DRIVE_MAX));
      d.right_drive = DRIVE_W'(clip(upright - turn, DRIVE_MIN, DRIVE_MAX));
      return d;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx,
                                     logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_TRIM_ANGLE: trim_angle_q = longint'($signed(value[ANGLE_W-1:0]));
         REG_UPRIGHT_KP: upright_kp_q = longint'($signed(value));
         REG_UPRIGHT_KD: upright_kd_q = longint'($signed(value));
         REG_SPEED_KP:   speed_kp_q   = longint'($signed(value));
         REG_SPEED_KI:   speed_ki_q   = longint'($signed(value));
         REG_TURN_GAIN:  turn_gain_q  = longint'($signed(value));
         default: ;  // unused slot, dropped
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: predicts on each accepted tick, checks each accepted drive pair,
   // applies register writes to the model and runs the watchdog.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : bus_monitor
      tick_type       got;
      drive_pair_type want;
      if (reset) begin
         trim_angle_q = TRIM_ANGLE_DEF;
         upright_kp_q = UPRIGHT_KP_DEF;
         upright_kd_q = UPRIGHT_KD_DEF;
         speed_kp_q   = SPEED_KP_DEF;
         speed_ki_q   = SPEED_KI_DEF;
         turn_gain_q  = TURN_GAIN_DEF;
         filt_err     = 0;
         err_integ    = 0;
         req_took     <= 1'b0;
         csr_took     <= 1'b0;
         idle_cycles  <= 0;
      end else begin
         req_took <= req_bus.valid && req_bus.ready;
         csr_took <= csr_bus.valid && csr_bus.ready;

         if (csr_bus.valid && csr_bus.ready) begin
            apply_reg(csr_bus.index, csr_bus.data);
            reg_writes <= reg_writes + 1;
         end

         if (req_bus.valid && !req_bus.ready)
            input_stall_cycles <= input_stall_cycles + 1;

         if (req_bus.valid && req_bus.ready) begin
            got.speed_goal  = req_bus.speed_goal;
            got.left_count  = req_bus.left_count;
            got.right_count = req_bus.right_count;
            got.roll_angle  = req_bus.roll_angle;
            got.gyro_y      = req_bus.gyro_y;
            got.gyro_z      = req_bus.gyro_z;
            expected_drives.push_back(predict_drives(got));
            ticks_taken <= ticks_taken + 1;
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            drives_checked <= drives_checked + 1;
            if (expected_drives.size() == 0) begin
               $display("%0t: unexpected drive transaction, left %0d right %0d",
                        $time, rsp_bus.left_drive, rsp_bus.right_drive);
               mismatches = mismatches + 1;
            end else begin
               want = expected_drives.pop_front();
               if (rsp_bus.left_drive !== want.left_drive) begin
                  $display("%0t: left_drive mismatch, expected %0d, got %0d",
                           $time, want.left_drive, rsp_bus.left_drive);
                  mismatches = mismatches + 1;
               end
               if (rsp_bus.right_drive !== want.right_drive) begin
                  $display("%0t: right_drive mismatch, expected %0d, got %0d",
                           $time, want.right_drive, rsp_bus.right_drive);
                  mismatches = mismatches + 1;
               end
            end
         end

         // watchdog: any transaction on any channel counts as progress
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d drive pairs outstanding",
                     $time, STALL_LIMIT, expected_drives.size());
            $display("FAIL balance_cascade_pid_core");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Pacing: mostly short gaps, now and then a long one, plus calm stretches
   // with no idling at all on either side.
   // ------------------------------------------------------------------------
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Tick driver, fed from tick_backlog. A presented tick is held until taken.
   always @(negedge clock) begin : tick_driver
      tick_type t;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
         req_calm      <= 0;
      end else if (req_bus.valid && !req_took) begin
         // still waiting for ready, hold everything
      end else if (req_gap != 0 && !req_eager) begin
         req_bus.valid <= 1'b0;
         req_gap       <= req_gap - 1;
      end else if (tick_backlog.size() != 0) begin
         t = tick_backlog.pop_front();
         req_bus.valid       <= 1'b1;
         req_bus.speed_goal  <= t.speed_goal;
         req_bus.left_count  <= t.left_count;
         req_bus.right_count <= t.right_count;
         req_bus.roll_angle  <= t.roll_angle;
         req_bus.gyro_y      <= t.gyro_y;
         req_bus.gyro_z      <= t.gyro_z;
         if (req_calm != 0) begin
            req_calm <= req_calm - 1;
            req_gap  <= 0;
         end else if ($urandom_range(0, 49) == 0) begin
            req_calm <= $urandom_range(20, 60);
            req_gap  <= 0;
         end else begin
            req_gap <= gap_length();
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Drive-side ready. A hold request from the stimulus turns into a long
   // hold-off counted here, so the pipe and the tick queue back up.
   always @(negedge clock) begin : drive_sink
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
         rsp_calm      <= 0;
         hold_left     <= 0;
         hold_served   <= 0;
      end else if (hold_served != hold_asked) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         hold_served   <= hold_served + 1;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (rsp_stall != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= rsp_stall - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (rsp_calm != 0)
            rsp_calm <= rsp_calm - 1;
         else if ($urandom_range(0, 49) == 0)
            rsp_calm <= $urandom_range(20, 60);
         else if ($urandom_range(0, 2) == 0)
            rsp_stall <= gap_length();
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_tick(int ts, int lc, int rc, int roll, int gy, int gz);
      tick_type t;
      t.speed_goal  = SENS_W'(ts);
      t.left_count  = SENS_W'(lc);
      t.right_count = SENS_W'(rc);
      t.roll_angle  = ANGLE_W'(roll);
      t.gyro_y      = SENS_W'(gy);
      t.gyro_z      = SENS_W'(gz);
      tick_backlog.push_back(t);
      ticks_queued++;
   endtask

   // 16-bit sensor value: extremes, small realistic values, or anything
   function automatic int rand_sens();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return 1;
         endcase
      end
      if (r < 60)
         return int'($urandom_range(0, 400)) - 200;
      return int'($signed(16'($urandom())));
   endfunction

   // roll in Q8.16: mostly within +-180 degrees, sometimes any 25-bit value
   function automatic int rand_roll();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 4))
            0: return ANGLE_SPAN;
            1: return -ANGLE_SPAN;
            2: return 16777215;
            3: return -16777216;
            default: return 0;
         endcase
      end
      if (r < 80)
         return int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN;
      return int'($signed(25'($urandom())));
   endfunction

   // Random ticks. Part of them look like a robot tracking its target
   // (counts split around the target), which keeps the integral off its clamp.
   task automatic queue_random_ticks(int n);
      int ts, lc;
      for (int i = 0; i < n; i++) begin
         ts = rand_sens();
         if ($urandom_range(0, 2) == 0) begin
            lc = ts / 2 + int'($urandom_range(0, 20)) - 10;
            push_tick(ts, lc, ts - lc + int'($urandom_range(0, 20)) - 10,
                      rand_roll(), rand_sens(), rand_sens());
         end else begin
            push_tick(ts, rand_sens(), rand_sens(), rand_roll(), rand_sens(), rand_sens());
         end
      end
   endtask

   // Returns at a falling edge once every queued tick is taken and answered.
   task automatic wait_drained();
      while (ticks_taken != ticks_queued || expected_drives.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after the
   // transaction, with valid still high so back-to-back writes stay clean.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(negedge clock);
      while (!csr_took)
         @(negedge clock);
   endtask

   // near-default gains, the range a tuned robot would use
   task automatic write_tuned_gains();
      write_reg(REG_TRIM_ANGLE, 32'(int'($urandom_range(0, 2 * 655360)) - 655360));
      write_reg(REG_UPRIGHT_KP, $urandom_range(0, 26214400));
      write_reg(REG_UPRIGHT_KD, $urandom_range(0, 131072));
      write_reg(REG_SPEED_KP,   $urandom_range(0, 65536));
      write_reg(REG_SPEED_KI,   $urandom_range(0, 400));
      write_reg(REG_TURN_GAIN,  32'(-int'($urandom_range(0, 131072))));
      csr_bus.valid <= 1'b0;
      settings_run++;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.speed_goal  = '0;
      req_bus.left_count  = '0;
      req_bus.right_count = '0;
      req_bus.roll_angle  = '0;
      req_bus.gyro_y      = '0;
      req_bus.gyro_z      = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;
      req_eager          = 1'b0;
      hold_asked         = 0;
      ticks_queued       = 0;
      ticks_taken        = 0;
      drives_checked     = 0;
      reg_writes         = 0;
      input_stall_cycles = 0;
      mismatches         = 0;
      settings_run       = 1;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed ticks at reset gains: field extremes, integral clamp both
      // ways, roll beyond +-180 degrees, drive saturation from either gyro.
      push_tick(0, 0, 0, 0, 0, 0);
      repeat (4) push_tick(-32768, 32767, 32767, 0, 0, 0);
      repeat (3) push_tick(32767, -32768, -32768, 0, 0, 0);
      push_tick(0, 0, 0, ANGLE_SPAN, 0, 0);
      push_tick(0, 0, 0, -ANGLE_SPAN, 0, 0);
      push_tick(0, 0, 0, 16777215, 0, 0);
      push_tick(0, 0, 0, -16777216, 0, 0);
      push_tick(0, 0, 0, 0, 32767, 0);
      push_tick(0, 0, 0, 0, -32768, 0);
      push_tick(0, 0, 0, 0, 0, 32767);
      push_tick(0, 0, 0, 0, 0, -32768);
      push_tick(-32768, -32768, -32768, -16777216, -32768, -32768);
      push_tick(32767, 32767, 32767, 16777215, 32767, 32767);
      push_tick(1, 0, 0, 257743, 0, 0);
      push_tick(0, -1, -1, -1, -1, -1);
      wait_drained();
      queue_random_ticks(110);
      wait_drained();

      // Fully random register contents; set-point data carries junk above
      // bit 24, and a write to an unused slot must change nothing.
      write_reg(REG_TRIM_ANGLE, $urandom());
      write_reg(REG_UPRIGHT_KP, $urandom());
      write_reg(REG_UPRIGHT_KD, $urandom());
      write_reg(REG_SPEED_KP,   $urandom());
      write_reg(REG_SPEED_KI,   $urandom());
      write_reg(REG_TURN_GAIN,  $urandom());
      write_reg(REG_SPARE_6,    $urandom());
      csr_bus.valid <= 1'b0;
      settings_run++;
      queue_random_ticks(80);
      wait_drained();

      // Largest gains and set-point. Big speed errors push the velocity term
      // far enough that the tilt error saturates at 32 bits.
      write_reg(REG_TRIM_ANGLE, 32'(ANGLE_SPAN));
      write_reg(REG_UPRIGHT_KP, 32'h7FFF_FFFF);
      write_reg(REG_UPRIGHT_KD, 32'h7FFF_FFFF);
      write_reg(REG_SPEED_KP,   32'h7FFF_FFFF);
      write_reg(REG_SPEED_KI,   32'h7FFF_FFFF);
      write_reg(REG_TURN_GAIN,  32'h7FFF_FFFF);
      write_reg(REG_SPARE_7,    32'hFFFF_FFFF);
      csr_bus.valid <= 1'b0;
      settings_run++;
      repeat (2) push_tick(-32768, 32767, 32767, 0, 0, 0);
      repeat (2) push_tick(32767, -32768, -32768, 0, 0, 0);
      queue_random_ticks(60);
      wait_drained();

      // Most negative gains and set-point
      write_reg(REG_TRIM_ANGLE, 32'(-ANGLE_SPAN));
      write_reg(REG_UPRIGHT_KP, 32'h8000_0000);
      write_reg(REG_UPRIGHT_KD, 32'h8000_0000);
      write_reg(REG_SPEED_KP,   32'h8000_0000);
      write_reg(REG_SPEED_KI,   32'h8000_0000);
      write_reg(REG_TURN_GAIN,  32'h8000_0000);
      csr_bus.valid <= 1'b0;
      settings_run++;
      queue_random_ticks(60);
      wait_drained();

      // All zero: drives must sit at zero whatever the sensors say
      write_reg(REG_TRIM_ANGLE, '0);
      write_reg(REG_UPRIGHT_KP, '0);
      write_reg(REG_UPRIGHT_KD, '0);
      write_reg(REG_SPEED_KP,   '0);
      write_reg(REG_SPEED_KI,   '0);
      write_reg(REG_TURN_GAIN,  '0);
      csr_bus.valid <= 1'b0;
      settings_run++;
      queue_random_ticks(40);
      wait_drained();

      // Back-pressure: drive side held off while ticks keep coming with no
      // gaps, so the queue fills and req ready has to drop.
      write_tuned_gains();
      req_eager  <= 1'b1;
      hold_asked <= hold_asked + 1;
      queue_random_ticks(40);
      wait_drained();
      req_eager <= 1'b0;

      // several tuned settings, the bulk of the run
      repeat (3) begin
         write_tuned_gains();
         queue_random_ticks(50);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d ticks over %0d register settings (%0d writes), %0d drive pairs checked.",
               ticks_taken, settings_run, reg_writes, drives_checked);
      $display("Tick input was back-pressured for %0d cycles; %0d mismatches seen.",
               input_stall_cycles, mismatches);
      if (mismatches == 0 && expected_drives.size() == 0)
         $display("PASS balance_cascade_pid_core");
      else
         $display("FAIL balance_cascade_pid_core");
      $finish;
   end

endmodule
